### sv/lsbr_pkg.sv
// Shared types and constants for the LSB-first bit reader.
package lsbr_pkg;

	localparam int STORE_BYTES_DEF = 4096;

	localparam int VALUE_W = 64;
	localparam int COUNT_W = 7;
	localparam int SPAN_BYTES = 9;
	localparam int SR_W = 8 * SPAN_BYTES;
	localparam int SPAN_W = 4;

	localparam logic [COUNT_W-1:0] MAX_BITS = 7'd64;
	localparam logic [SPAN_W-1:0] FETCH_LAST = 4'(SPAN_BYTES);

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FETCH,
		ST_FINISH
	} state_t;

	// control from the sequencer to the shift register
	typedef struct packed {
		logic shift;
		logic take;
	} shift_ctl_t;

endpackage

### sv/lsbr_store.sv
// Byte store: byte-wide memory filled in order, plus its fill count.
module lsbr_store #(
	parameter int STORE_BYTES = lsbr_pkg::STORE_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [7:0]                         wr_data,
	input  logic                               rd_en,
	input  logic [$clog2(STORE_BYTES)-1:0]     rd_addr,
	output logic [7:0]                         rd_data,
	output logic [$clog2(STORE_BYTES+1)-1:0]   fill
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int FW = $clog2(STORE_BYTES + 1);

	logic [7:0]    mem [STORE_BYTES];
	logic [FW-1:0] fill_q;
	logic [7:0]    rd_data_q;
	logic          do_wr;

	// loads past a full store are dropped
	assign do_wr = wr_en && (fill_q != FW'(STORE_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (do_wr) begin
			fill_q <= fill_q + FW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[fill_q[AW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign fill = fill_q;

endmodule

### sv/lsbr_shift.sv
// Nine-byte shift register with offset alignment and bit-count mask.
module lsbr_shift (
	input  logic                              clk,
	input  lsbr_pkg::shift_ctl_t              ctl,
	input  logic [7:0]                        in_byte,
	input  logic [2:0]                        off,
	input  logic [lsbr_pkg::COUNT_W-1:0]      n,
	output logic [lsbr_pkg::VALUE_W-1:0]      value
);

	logic [lsbr_pkg::SR_W-1:0]    sr_q;
	logic [lsbr_pkg::SR_W-1:0]    aligned;
	logic [lsbr_pkg::VALUE_W-1:0] mask;

	// bytes enter at the top; after a full pass the first byte sits in bits 7:0
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			sr_q <= {(ctl.take ? in_byte : 8'h00), sr_q[lsbr_pkg::SR_W-1:8]};
		end
	end

	always_comb begin
		aligned = sr_q >> off;
		if (n[lsbr_pkg::COUNT_W-1]) begin
			mask = '1;
		end else begin
			mask = (lsbr_pkg::VALUE_W'(1) << n[lsbr_pkg::COUNT_W-2:0])
				- lsbr_pkg::VALUE_W'(1);
		end
		value = aligned[lsbr_pkg::VALUE_W-1:0] & mask;
	end

endmodule

### sv/lsb_first_bit_reader.sv
// Top level of the LSB-first bit reader: sequencer, cursor and result registers.
//
// Usage:
//   A word is accepted when start is high and busy is low. req_type selects
//   a load (load_byte is appended to the byte store) or a read of bit_count
//   bits (values above 64 saturate to 64) from the read cursor.
//   Loads raise no busy and give no result.
//   A read raises busy and gives exactly one result word: done pulses for a
//   single cycle with read_value (first bit read in bit 0) and past_end.
//   A read that would pass the loaded bytes returns past_end = 1, value 0 and
//   leaves the cursor alone; its result is registered in the check state.
//   A zero-bit read also answers from the check state. Any other read walks nine
//   byte slots through the shift register, one memory read per cycle from the
//   single byte-wide store port for each byte that the read touches, and answers
//   from the finish state; the next word is accepted once the block is idle again.
//   The receiver cannot stall: done is a strobe and must be taken when shown.
//   Reset clears the fill count, the cursor and the sequencer; store contents
//   stay undefined until loaded and need no clearing pass.
module lsb_first_bit_reader #(
	parameter int STORE_BYTES = lsbr_pkg::STORE_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               req_type,
	input  logic [7:0]                         load_byte,
	input  logic [lsbr_pkg::COUNT_W-1:0]       bit_count,
	output logic                               done,
	output logic [lsbr_pkg::VALUE_W-1:0]       read_value,
	output logic                               past_end
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int FW = $clog2(STORE_BYTES + 1);
	localparam int CW = FW + 3;   // cursor in bits: byte position and bit offset

	lsbr_pkg::state_t state_q, state_d;

	// cursor
	logic [FW-1:0] pos_q;
	logic [2:0]    off_q;

	// current read
	logic [lsbr_pkg::COUNT_W-1:0] n_q;
	logic [lsbr_pkg::SPAN_W-1:0]  nb_q;
	logic [lsbr_pkg::SPAN_W-1:0]  cnt_q;
	logic                         iss_s1;   // store read data valid this cycle

	// result registers
	logic                         done_q;
	logic                         past_end_q;
	logic [lsbr_pkg::VALUE_W-1:0] read_value_q;

	logic                         accept;
	logic                         wr_en;
	logic                         rd_en;
	logic [FW-1:0]                rd_pos;
	logic [7:0]                   rd_data;
	logic [FW-1:0]                fill;
	logic                         overrun;
	logic [CW:0]                  end_bit;
	logic [6:0]                   span_sum;
	logic [CW-1:0]                cursor_next;
	logic [lsbr_pkg::COUNT_W-1:0] n_sat;
	logic [lsbr_pkg::VALUE_W-1:0] shift_value;
	lsbr_pkg::shift_ctl_t         sctl;

	assign accept = start && !busy;
	assign n_sat  = (bit_count > lsbr_pkg::MAX_BITS) ? lsbr_pkg::MAX_BITS : bit_count;

	// bit position that the read would end at, against loaded bits
	assign end_bit  = (CW + 1)'({pos_q, off_q}) + (CW + 1)'(n_q);
	assign overrun  = end_bit > {1'b0, fill, 3'b000};
	// bytes touched: ceil((offset + count) / 8)
	assign span_sum = 7'(off_q) + n_q + 7'd7;
	assign cursor_next = {pos_q, off_q} + CW'(n_q);
	assign rd_pos = pos_q + FW'(cnt_q);

	lsbr_store #(
		.STORE_BYTES (STORE_BYTES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (load_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_pos[AW-1:0]),
		.rd_data (rd_data),
		.fill    (fill)
	);

	lsbr_shift u_shift (
		.clk     (clk),
		.ctl     (sctl),
		.in_byte (rd_data),
		.off     (off_q),
		.n       (n_q),
		.value   (shift_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsbr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d    = state_q;
		busy       = 1'b1;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		sctl.shift = 1'b0;
		sctl.take  = 1'b0;
		case (state_q)
			lsbr_pkg::ST_IDLE: begin
				busy  = 1'b0;
				wr_en = start && (req_type == lsbr_pkg::REQ_LOAD);
				if (start && (req_type == lsbr_pkg::REQ_READ)) begin
					state_d = lsbr_pkg::ST_CHECK;
				end
			end
			lsbr_pkg::ST_CHECK: begin
				if (overrun || (n_q == '0)) begin
					state_d = lsbr_pkg::ST_IDLE;
				end else begin
					state_d = lsbr_pkg::ST_FETCH;
				end
			end
			lsbr_pkg::ST_FETCH: begin
				rd_en      = cnt_q < nb_q;
				sctl.shift = cnt_q != '0;
				sctl.take  = iss_s1;
				if (cnt_q == lsbr_pkg::FETCH_LAST) begin
					state_d = lsbr_pkg::ST_FINISH;
				end
			end
			lsbr_pkg::ST_FINISH: begin
				state_d = lsbr_pkg::ST_IDLE;
			end
			default: begin
				state_d = lsbr_pkg::ST_IDLE;
			end
		endcase
	end

	// cursor, sequencing counters and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			off_q  <= '0;
			done_q <= 1'b0;
			iss_s1 <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			iss_s1 <= rd_en;
			case (state_q)
				lsbr_pkg::ST_CHECK: begin
					cnt_q <= '0;
					if (overrun || (n_q == '0)) begin
						done_q <= 1'b1;
					end
				end
				lsbr_pkg::ST_FETCH: begin
					cnt_q <= cnt_q + lsbr_pkg::SPAN_W'(1);
				end
				lsbr_pkg::ST_FINISH: begin
					done_q <= 1'b1;
					pos_q  <= cursor_next[CW-1:3];
					off_q  <= cursor_next[2:0];
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= n_sat;
		end
		if (state_q == lsbr_pkg::ST_CHECK) begin
			nb_q         <= span_sum[6:3];
			past_end_q   <= overrun;
			read_value_q <= '0;
		end
		if (state_q == lsbr_pkg::ST_FINISH) begin
			past_end_q   <= 1'b0;
			read_value_q <= shift_value;
		end
	end

	assign done       = done_q;
	assign past_end   = past_end_q;
	assign read_value = read_value_q;

	// a result only follows a check or the final assembly step
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == lsbr_pkg::ST_CHECK
			|| $past(state_q) == lsbr_pkg::ST_FINISH))
		else $error("result strobe without a finished read");

	// an overrun answer carries zero data
	a_past_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && past_end) |-> (read_value == '0))
		else $error("past_end result with nonzero data");

	// the cursor never runs ahead of the loaded bytes
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, pos_q, off_q} <= {1'b0, fill, 3'b000}))
		else $error("read cursor beyond loaded bytes");

	// an accepted read always occupies the block
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == lsbr_pkg::REQ_READ)) |=> busy)
		else $error("read accepted without going busy");

endmodule
